FILE: hdl/xs256_pkg.sv
// Shared constants, codes, the controller-to-datapath command type and the status type.
package xs256_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned HalfW = 32;

  localparam logic [WordW-1:0] GOLDEN_GAMMA = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [WordW-1:0] MIX_MUL_A    = 64'hbf58_476d_1ce4_e5b9;
  localparam logic [WordW-1:0] MIX_MUL_B    = 64'h94d0_49bb_1331_11eb;

  localparam logic [WordW-1:0] RESET_WORD_ZERO  = 64'h1234_5678_9abc_def0;
  localparam logic [WordW-1:0] RESET_WORD_ONE   = 64'h0000_0000_0000_0042;
  localparam logic [WordW-1:0] RESET_WORD_TWO   = 64'h0000_0000_0000_1337;
  localparam logic [WordW-1:0] RESET_WORD_THREE = 64'h0000_0000_dead_beef;

  // Input item kinds carried on tuser.
  localparam logic MODE_SEED = 1'b0;
  localparam logic MODE_DRAW = 1'b1;

  // Partial product selects for a 64x64 low-half multiply.
  localparam logic [1:0] PP_LL = 2'd0;  // a_lo * b_lo, full 64 bits
  localparam logic [1:0] PP_LH = 2'd1;  // a_lo * b_hi, low 32 bits into upper half
  localparam logic [1:0] PP_HL = 2'd2;  // a_hi * b_lo, low 32 bits into upper half

  // Multiplier constant selects.
  localparam logic CONST_A = 1'b0;
  localparam logic CONST_B = 1'b1;

  // State word targets of a mix store.
  localparam logic [1:0] WORD_ONE   = 2'd1;
  localparam logic [1:0] WORD_TWO   = 2'd2;
  localparam logic [1:0] WORD_THREE = 2'd3;

  typedef struct packed {
    logic       load_seed;
    logic       draw;
    logic       mix_pre;
    logic       mul_en;
    logic [1:0] pp_sel;
    logic       const_sel;
    logic       mix_mid;
    logic       store;
    logic [1:0] word_sel;
  } cmd_t;

  typedef struct packed {
    logic out_valid;
  } status_t;

endpackage

FILE: hdl/xs256_datapath.sv
// State words, draw update, seed mixing unit and output register.
module xs256_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  xs256_pkg::cmd_t              cmd,
  output xs256_pkg::status_t           status,
  input  logic [xs256_pkg::WordW-1:0]  seed_value,
  input  logic                         out_ready,
  output logic [xs256_pkg::WordW-1:0]  random_value
);

  localparam int unsigned W = xs256_pkg::WordW;
  localparam int unsigned H = xs256_pkg::HalfW;

  logic [W-1:0] word_zero, word_one, word_two, word_three;
  logic [W-1:0] chain;
  logic [W-1:0] opnd;
  logic [W-1:0] acc;
  logic [W-1:0] out_data;
  logic         out_valid;

  logic [W-1:0] draw_result;
  logic [W-1:0] sum03;
  logic [W-1:0] shift_t;
  logic [W-1:0] n0, n1, n2, n3;
  logic [W-1:0] pre_z;
  logic [W-1:0] mid_x;
  logic [W-1:0] mixed;
  logic [W-1:0] mul_const;
  logic [H-1:0] a_half, b_half;
  logic [W-1:0] prod;

  // Draw: output function and xor/shift/rotate state update.
  always_comb begin
    sum03       = word_zero + word_three;
    draw_result = {sum03[W-24:0], sum03[W-1:W-23]} + word_zero;
    shift_t     = {word_one[W-18:0], 17'd0};
    n2          = word_two ^ word_zero;
    n3          = word_three ^ word_one;
    n1          = word_one ^ n2;
    n0          = word_zero ^ n3;
    n2          = n2 ^ shift_t;
    n3          = {n3[W-46:0], n3[W-1:W-45]};
  end

  // Seed mixing: xor-shift stages around one shared 32x32 multiplier.
  always_comb begin
    pre_z     = chain + xs256_pkg::GOLDEN_GAMMA;
    mid_x     = acc ^ (acc >> 27);
    mixed     = acc ^ (acc >> 31);
    mul_const = (cmd.const_sel == xs256_pkg::CONST_B) ? xs256_pkg::MIX_MUL_B
                                                       : xs256_pkg::MIX_MUL_A;
    a_half    = (cmd.pp_sel == xs256_pkg::PP_HL) ? opnd[W-1:H] : opnd[H-1:0];
    b_half    = (cmd.pp_sel == xs256_pkg::PP_LH) ? mul_const[W-1:H] : mul_const[H-1:0];
    prod      = W'(a_half) * W'(b_half);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_zero  <= xs256_pkg::RESET_WORD_ZERO;
      word_one   <= xs256_pkg::RESET_WORD_ONE;
      word_two   <= xs256_pkg::RESET_WORD_TWO;
      word_three <= xs256_pkg::RESET_WORD_THREE;
    end else if (cmd.draw) begin
      word_zero  <= n0;
      word_one   <= n1;
      word_two   <= n2;
      word_three <= n3;
    end else if (cmd.load_seed) begin
      word_zero <= seed_value;
    end else if (cmd.store) begin
      unique case (cmd.word_sel)
        xs256_pkg::WORD_ONE:   word_one   <= mixed;
        xs256_pkg::WORD_TWO:   word_two   <= mixed;
        xs256_pkg::WORD_THREE: word_three <= mixed;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_seed) begin
      chain <= seed_value;
    end else if (cmd.store) begin
      chain <= mixed;
    end
    if (cmd.mix_pre) begin
      opnd <= pre_z ^ (pre_z >> 30);
    end else if (cmd.mix_mid) begin
      opnd <= mid_x;
    end
    if (cmd.mul_en) begin
      case (cmd.pp_sel) inside
        xs256_pkg::PP_LL:                   acc <= prod;
        xs256_pkg::PP_LH, xs256_pkg::PP_HL: acc[W-1:H] <= acc[W-1:H] + prod[H-1:0];
        default: ;
      endcase
    end
  end

  // Output register: a new draw may load it in the cycle the old result leaves.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.draw) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.draw) begin
      out_data <= draw_result;
    end
  end

  assign status.out_valid = out_valid;
  assign random_value     = out_data;

endmodule

FILE: hdl/xs256_ctrl.sv
// Controller: input handshake and the seed mixing sequence.
module xs256_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_mode,
  output logic                in_ready,
  input  logic                out_ready,
  input  xs256_pkg::status_t  status,
  output xs256_pkg::cmd_t     cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PRE   = 3'd1;
  localparam logic [2:0] ST_MUL1  = 3'd2;
  localparam logic [2:0] ST_MID   = 3'd3;
  localparam logic [2:0] ST_MUL2  = 3'd4;
  localparam logic [2:0] ST_STORE = 3'd5;

  logic [2:0] state, state_next;
  logic [1:0] pp_cnt, pp_cnt_next;
  logic [1:0] word_cnt, word_cnt_next;
  logic       accept;

  assign in_ready = (state == ST_IDLE) && (!status.out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next    = state;
    pp_cnt_next   = pp_cnt;
    word_cnt_next = word_cnt;
    cmd           = '0;
    cmd.pp_sel    = pp_cnt;
    cmd.word_sel  = word_cnt;
    unique case (state)
      ST_IDLE: begin
        if (accept && in_mode == xs256_pkg::MODE_DRAW) begin
          cmd.draw = 1'b1;
        end else if (accept) begin
          cmd.load_seed = 1'b1;
          word_cnt_next = xs256_pkg::WORD_ONE;
          state_next    = ST_PRE;
        end
      end
      ST_PRE: begin
        cmd.mix_pre = 1'b1;
        pp_cnt_next = xs256_pkg::PP_LL;
        state_next  = ST_MUL1;
      end
      ST_MUL1: begin
        cmd.mul_en    = 1'b1;
        cmd.const_sel = xs256_pkg::CONST_A;
        if (pp_cnt == xs256_pkg::PP_HL) begin
          pp_cnt_next = xs256_pkg::PP_LL;
          state_next  = ST_MID;
        end else begin
          pp_cnt_next = pp_cnt + 2'd1;
        end
      end
      ST_MID: begin
        cmd.mix_mid = 1'b1;
        state_next  = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul_en    = 1'b1;
        cmd.const_sel = xs256_pkg::CONST_B;
        if (pp_cnt == xs256_pkg::PP_HL) begin
          pp_cnt_next = xs256_pkg::PP_LL;
          state_next  = ST_STORE;
        end else begin
          pp_cnt_next = pp_cnt + 2'd1;
        end
      end
      ST_STORE: begin
        cmd.store = 1'b1;
        if (word_cnt == xs256_pkg::WORD_THREE) begin
          state_next = ST_IDLE;
        end else begin
          word_cnt_next = word_cnt + 2'd1;
          state_next    = ST_PRE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      pp_cnt   <= xs256_pkg::PP_LL;
      word_cnt <= xs256_pkg::WORD_ONE;
    end else begin
      state    <= state_next;
      pp_cnt   <= pp_cnt_next;
      word_cnt <= word_cnt_next;
    end
  end

endmodule

FILE: hdl/xoshiro256pp_generator_top.sv
// Top level of the xoshiro256++ generator: stream ports, controller and datapath.
// A draw item (tuser = 1) is taken and its 64-bit result appears on the output
// register the next cycle; draws can be taken every cycle while the output is being
// drained. A seed item (tuser = 0) gives no result and holds the input off until the
// seed mixing ends: the three chained splitmix mixes each need two 64-bit multiplies,
// each built from three partial products on the one shared 32x32 multiplier (one
// partial product per cycle), plus xor-shift steps in the PRE, MID and STORE states of
// each mixed word. Draws before any seed use the fixed reset state.
module xoshiro256pp_generator_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [xs256_pkg::WordW-1:0]  s_axis_tdata,   // [63:0] seed_value
  input  logic                         s_axis_tuser,   // [0] mode
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [xs256_pkg::WordW-1:0]  m_axis_tdata    // [63:0] random_value
);

  xs256_pkg::cmd_t    cmd;
  xs256_pkg::status_t status;

  xs256_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_mode   (s_axis_tuser),
    .in_ready  (s_axis_tready),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  xs256_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .seed_value   (s_axis_tdata),
    .out_ready    (m_axis_tready),
    .random_value (m_axis_tdata)
  );

  assign m_axis_tvalid = status.out_valid;

endmodule
